// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the identifier allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies another on the following clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/idalloc_pkg.sv -----
// Types and constants shared by the identifier allocator modules.
package idalloc_pkg;

   localparam int ID_W   = 12;
   localparam int STAT_W = 2;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK           = 2'd0;
   localparam logic [STAT_W-1:0] ST_EXHAUSTED    = 2'd1;
   localparam logic [STAT_W-1:0] ST_FREE_IGNORED = 2'd2;

   typedef struct packed {
      logic            cmd;
      logic [ID_W-1:0] release_id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]   granted_id;
      logic [STAT_W-1:0] status;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic commit;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic out_free;
   } dp_stat_type;

endpackage

// ----- rtl/idalloc_ctrl.sv -----
// Controller state machine: accept an item, then commit it when the output slot is free.
module idalloc_ctrl
   import idalloc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output dp_cmd_type  dp_cmd,
   input  dp_stat_type dp_stat
);

   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_EXEC = 1'b1;

   logic [0:0] state_ff;
   logic [0:0] state_in;

   always_comb begin
      state_in      = state_ff;
      dp_cmd.load   = 1'b0;
      dp_cmd.commit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold until the result register can take the item
            if (dp_stat.out_free) begin
               dp_cmd.commit = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/idalloc_dp.sv -----
// Datapath: free queue, free bitmap, bump counter, pointers and result register.
module idalloc_dp
   import idalloc_pkg::*;
#(
   parameter int MAX_IDS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  dp_cmd_type  dp_cmd,
   output dp_stat_type dp_stat
);

   localparam int PTR_W     = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
   localparam int CNT_W     = $clog2(MAX_IDS + 1);
   localparam int MAP_DEPTH = (MAX_IDS < (1 << ID_W)) ? MAX_IDS : (1 << ID_W);
   localparam int MAP_W     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int CMP_W     = (CNT_W > ID_W) ? CNT_W : ID_W;

   localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_IDS);
   localparam logic [CNT_W-1:0] MAP_CNT  = CNT_W'(MAP_DEPTH);
   localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(MAX_IDS - 1);

   logic [ID_W-1:0] queue_mem [MAX_IDS];
   logic            map_mem   [MAP_DEPTH];

   logic             op_ff;
   logic [ID_W-1:0]  rid_ff;
   logic [ID_W-1:0]  q_rd_ff;
   logic             map_rd_ff;
   logic [CNT_W-1:0] bump_ff,  bump_in;
   logic [PTR_W-1:0] head_ff,  head_in;
   logic [PTR_W-1:0] tail_ff,  tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;

   logic             from_queue, from_bump, free_ok;
   logic             q_we, map_we, map_wd;
   logic [MAP_W-1:0] map_wa;

   assign from_queue = (op_ff == CMD_ALLOC) && (count_ff != '0);
   assign from_bump  = (op_ff == CMD_ALLOC) && !from_queue && (bump_ff < MAX_CNT);
   // every bitmap entry below the counter has been written since reset
   assign free_ok    = (op_ff == CMD_FREE) && (CMP_W'(rid_ff) < CMP_W'(bump_ff))
                       && !map_rd_ff && (count_ff < MAX_CNT);

   always_comb begin
      bump_in  = bump_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      q_we     = 1'b0;
      map_we   = 1'b0;
      map_wd   = 1'b0;
      map_wa   = rid_ff[MAP_W-1:0];
      rsp_in.granted_id = '0;
      rsp_in.status     = ST_OK;
      priority if (from_queue) begin
         head_in  = (head_ff == LAST_POS) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
         map_we   = dp_cmd.commit;
         map_wa   = q_rd_ff[MAP_W-1:0];
         rsp_in.granted_id = q_rd_ff;
      end else if (from_bump) begin
         bump_in = bump_ff + 1'b1;
         // clear the entry as the counter passes it
         map_we  = dp_cmd.commit && (bump_ff < MAP_CNT);
         map_wa  = bump_ff[MAP_W-1:0];
         rsp_in.granted_id = ID_W'(bump_ff);
      end else if (op_ff == CMD_ALLOC) begin
         rsp_in.status = ST_EXHAUSTED;
      end else if (free_ok) begin
         tail_in  = (tail_ff == LAST_POS) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
         q_we     = dp_cmd.commit;
         map_we   = dp_cmd.commit;
         map_wd   = 1'b1;
      end else begin
         rsp_in.status = ST_FREE_IGNORED;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         op_ff     <= req_payload.cmd;
         rid_ff    <= req_payload.release_id;
         q_rd_ff   <= queue_mem[head_ff];
         map_rd_ff <= map_mem[req_payload.release_id[MAP_W-1:0]];
      end
      if (q_we) begin
         queue_mem[tail_ff] <= rid_ff;
      end
      if (map_we) begin
         map_mem[map_wa] <= map_wd;
      end
      if (dp_cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bump_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (dp_cmd.commit) begin
            bump_ff  <= bump_in;
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
         if (dp_cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign dp_stat.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload      = rsp_ff;

endmodule

// ----- rtl/id_allocator_free_list_top.sv -----
// Top level of the identifier allocator with FIFO free list.
//
//   port group    dir   payload     role
//   req_*         in    req_type    allocate or free command
//   rsp_*         out   rsp_type    granted identifier and status
//
// Each item passes through a load step, which registers the free queue and bitmap
// reads, and a commit step, which applies the update and loads the result register.
// A new item is accepted only once the previous one has been committed.
// Reset needs no clearing pass; the bitmap is written as the counter advances.
// A stalled result holds in the output register; one more item may be taken
// and then waits in the commit state until the result is drained.
`include "assert_macros.svh"

module id_allocator_free_list_top
   import idalloc_pkg::*;
#(
   parameter int MAX_IDS = 4096
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   idalloc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   idalloc_dp #(
      .MAX_IDS (MAX_IDS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .dp_cmd      (dp_cmd),
      .dp_stat     (dp_stat)
   );

   `ASSERT_NEXT(a_accept_blocks, req_valid && !req_stall, req_stall, "accept did not block next item")
   `ASSERT_NEXT(a_commit_shows, dp_cmd.commit, rsp_valid, "committed item not presented")
   `ASSERT_ALWAYS(a_load_commit_excl, !(dp_cmd.load && dp_cmd.commit), "load and commit together")

endmodule

// ----- bench/testbench.sv -----
// Testbench for the identifier allocator: allocate and free traffic checked against a predictor.
`timescale 1ns / 100ps

module testbench;
   import idalloc_pkg::*;

   localparam int MAX_IDS  = 4096;
   localparam int HOLD_OFF = 400;

   // Tracks which identifiers are fresh, queued or handed out, and the grants still owed.
   class grant_checker;
      bit [ID_W:0]   next_fresh;
      bit [ID_W-1:0] free_fifo[$];
      bit            queued[MAX_IDS];
      rsp_type       pending_grants[$];
      int            errors;

      function void report(string what);
         errors++;
         if (errors <= 10) $display("%0t ns: %s", $time, what);
      endfunction

      function rsp_type note_request(req_type item);
         rsp_type res;
         res.granted_id = '0;
         res.status     = ST_OK;
         if (item.cmd == CMD_ALLOC) begin
            if (free_fifo.size() != 0) begin
               // take the oldest freed id
               res.granted_id = free_fifo[0];
               free_fifo.delete(0);
               queued[res.granted_id] = 1'b0;
            end else if (next_fresh < MAX_IDS) begin
               res.granted_id = next_fresh[ID_W-1:0];
               next_fresh++;
            end else begin
               res.status = ST_EXHAUSTED;
            end
         end else if (item.release_id < next_fresh && !queued[item.release_id]) begin
            free_fifo.push_back(item.release_id);
            queued[item.release_id] = 1'b1;
         end else begin
            res.status = ST_FREE_IGNORED;
         end
         pending_grants.push_back(res);
         return res;
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_grants.size() == 0) begin
            report($sformatf("unexpected item: id %0d status %0d",
                             got.granted_id, got.status));
            return;
         end
         want = pending_grants[0];
         pending_grants.delete(0);
         if (got.granted_id !== want.granted_id || got.status !== want.status)
            report($sformatf("expected id %0d status %0d, got id %0d status %0d",
                             want.granted_id, want.status, got.granted_id, got.status));
      endfunction
   endclass

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   grant_checker    board;
   logic [ID_W-1:0] held_ids[$];
   bit              quiet;
   bit              want_long_hold;
   int              send_idle_pct = 20;
   int              stall_pct = 10;
   int              sent;

   id_allocator_free_list_top #(.MAX_IDS(MAX_IDS)) dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic req_type make_req(logic cmd, logic [ID_W-1:0] id);
      req_type item;
      item.cmd        = cmd;
      item.release_id = id;
      return item;
   endfunction

   // Mostly allocates and frees of held ids, with duplicates and stray ids mixed in.
   function automatic req_type random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55 || (pick < 85 && held_ids.size() == 0))
         return make_req(CMD_ALLOC, ID_W'($urandom));
      if (pick < 85)
         return make_req(CMD_FREE, held_ids[$urandom_range(0, held_ids.size() - 1)]);
      if (pick < 92 && board.free_fifo.size() != 0)
         return make_req(CMD_FREE,
                         board.free_fifo[$urandom_range(0, board.free_fifo.size() - 1)]);
      return make_req(CMD_FREE, $urandom_range(0, 1) ? ID_W'($urandom)
                                                    : board.next_fresh[ID_W-1:0]);
   endfunction

   task automatic offer(input req_type item, output rsp_type outcome);
      if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall !== 1'b0);
      outcome = board.note_request(item);
      if (item.cmd == CMD_ALLOC && outcome.status == ST_OK) begin
         held_ids.push_back(outcome.granted_id);
      end else if (item.cmd == CMD_FREE && outcome.status == ST_OK) begin
         for (int i = 0; i < held_ids.size(); i++) begin
            if (held_ids[i] == item.release_id) begin
               held_ids.delete(i);
               break;
            end
         end
      end
      sent++;
      if (sent % 64 == 0) begin
         case ($urandom_range(0, 2))
            0: send_idle_pct = 0;
            1: send_idle_pct = 10;
            default: send_idle_pct = 40;
         endcase
      end
   endtask

   // Result side: check each item, stall in bursts, and hold off once for a long stretch.
   initial begin
      int hold;
      int cycle;
      hold  = 0;
      cycle = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) board.check_response(rsp_payload);
         cycle++;
         if (cycle % 128 == 0) begin
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 5;
               default: stall_pct = 20;
            endcase
         end
         if (hold > 0) begin
            hold--;
         end else if (want_long_hold) begin
            hold = HOLD_OFF;
            want_long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
            hold = $urandom_range(1, 16);
         end
         rsp_stall <= (hold > 0);
      end
   end

   initial begin
      rsp_type outcome;
      int      waited;
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Opening sequence: frees before anything is handed out, FIFO order, duplicates.
      offer(make_req(CMD_FREE, 12'd0), outcome);
      offer(make_req(CMD_FREE, 12'd4095), outcome);
      offer(make_req(CMD_ALLOC, 12'hFFF), outcome);
      offer(make_req(CMD_ALLOC, 12'd0), outcome);
      offer(make_req(CMD_ALLOC, 12'hAAA), outcome);
      offer(make_req(CMD_ALLOC, 12'h555), outcome);
      offer(make_req(CMD_FREE, 12'd2), outcome);
      offer(make_req(CMD_FREE, 12'd2), outcome);
      offer(make_req(CMD_FREE, 12'd0), outcome);
      offer(make_req(CMD_FREE, 12'd4), outcome);
      offer(make_req(CMD_FREE, 12'd3), outcome);
      offer(make_req(CMD_ALLOC, 12'd0), outcome);
      offer(make_req(CMD_ALLOC, 12'd0), outcome);
      offer(make_req(CMD_FREE, 12'd0), outcome);
      offer(make_req(CMD_ALLOC, 12'd0), outcome);
      offer(make_req(CMD_ALLOC, 12'd0), outcome);
      offer(make_req(CMD_ALLOC, 12'd0), outcome);
      offer(make_req(CMD_FREE, 12'd4095), outcome);

      for (int n = 0; n < 1430; n++) begin
         if (n == 400) want_long_hold = 1'b1;
         offer(random_item(), outcome);
      end

      quiet = 1'b1;
      for (int n = 0; n < 200; n++) offer(random_item(), outcome);

      req_valid <= 1'b0;
      waited = 0;
      while (board.pending_grants.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (board.pending_grants.size() != 0)
         board.report($sformatf("%0d expected items never arrived",
                                board.pending_grants.size()));
      if (board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
